// File: hw/rtl/rid_pkg.sv
`default_nettype none
package rid_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned OPN_W  = 7;
  localparam int unsigned KIND_W = 7;
  localparam int unsigned PACK_W = 64;

  // operand kinds
  localparam logic [KIND_W-1:0] KIND_RD_RS     = 7'd3;
  localparam logic [KIND_W-1:0] KIND_REG3      = 7'd7;
  localparam logic [KIND_W-1:0] KIND_REG3_BP   = 7'd15;
  localparam logic [KIND_W-1:0] KIND_REG2_IMM  = 7'd19;
  localparam logic [KIND_W-1:0] KIND_REG_IMM   = 7'd17;
  localparam logic [KIND_W-1:0] KIND_REG_WIDE  = 7'd33;
  localparam logic [KIND_W-1:0] KIND_TARGET    = 7'd64;

  // operation numbers
  localparam logic [OPN_W-1:0] OP_J       = 7'd0;
  localparam logic [OPN_W-1:0] OP_JAL     = 7'd1;
  localparam logic [OPN_W-1:0] OP_BEQ     = 7'd2;
  localparam logic [OPN_W-1:0] OP_BNE     = 7'd3;
  localparam logic [OPN_W-1:0] OP_ADDIU   = 7'd4;
  localparam logic [OPN_W-1:0] OP_SLTI    = 7'd5;
  localparam logic [OPN_W-1:0] OP_SLTIU   = 7'd6;
  localparam logic [OPN_W-1:0] OP_ANDI    = 7'd7;
  localparam logic [OPN_W-1:0] OP_ORI     = 7'd8;
  localparam logic [OPN_W-1:0] OP_XORI    = 7'd9;
  localparam logic [OPN_W-1:0] OP_AUI     = 7'd10;
  localparam logic [OPN_W-1:0] OP_BGEC    = 7'd11;
  localparam logic [OPN_W-1:0] OP_BLTC    = 7'd12;
  localparam logic [OPN_W-1:0] OP_BC      = 7'd13;
  localparam logic [OPN_W-1:0] OP_BALC    = 7'd14;
  localparam logic [OPN_W-1:0] OP_SLL     = 7'd15;
  localparam logic [OPN_W-1:0] OP_SRA     = 7'd16;
  localparam logic [OPN_W-1:0] OP_SLLV    = 7'd17;
  localparam logic [OPN_W-1:0] OP_LSA     = 7'd18;
  localparam logic [OPN_W-1:0] OP_SRAV    = 7'd19;
  localparam logic [OPN_W-1:0] OP_CLZ     = 7'd20;
  localparam logic [OPN_W-1:0] OP_CLO     = 7'd21;
  localparam logic [OPN_W-1:0] OP_ADD     = 7'd22;
  localparam logic [OPN_W-1:0] OP_ADDU    = 7'd23;
  localparam logic [OPN_W-1:0] OP_SUB     = 7'd24;
  localparam logic [OPN_W-1:0] OP_SUBU    = 7'd25;
  localparam logic [OPN_W-1:0] OP_AND     = 7'd26;
  localparam logic [OPN_W-1:0] OP_OR      = 7'd27;
  localparam logic [OPN_W-1:0] OP_XOR     = 7'd28;
  localparam logic [OPN_W-1:0] OP_NOR     = 7'd29;
  localparam logic [OPN_W-1:0] OP_SLT     = 7'd30;
  localparam logic [OPN_W-1:0] OP_SLTU    = 7'd31;
  localparam logic [OPN_W-1:0] OP_ROTR    = 7'd32;
  localparam logic [OPN_W-1:0] OP_SRL     = 7'd33;
  localparam logic [OPN_W-1:0] OP_ROTRV   = 7'd34;
  localparam logic [OPN_W-1:0] OP_SRLV    = 7'd35;
  localparam logic [OPN_W-1:0] OP_JALR_HB = 7'd36;
  localparam logic [OPN_W-1:0] OP_JALR    = 7'd37;
  localparam logic [OPN_W-1:0] OP_MUL     = 7'd38;
  localparam logic [OPN_W-1:0] OP_MUH     = 7'd39;
  localparam logic [OPN_W-1:0] OP_MULU    = 7'd40;
  localparam logic [OPN_W-1:0] OP_MUHU    = 7'd41;
  localparam logic [OPN_W-1:0] OP_DIV     = 7'd42;
  localparam logic [OPN_W-1:0] OP_MOD     = 7'd43;
  localparam logic [OPN_W-1:0] OP_DIVU    = 7'd44;
  localparam logic [OPN_W-1:0] OP_MODU    = 7'd45;
  localparam logic [OPN_W-1:0] OP_BLTZ    = 7'd46;
  localparam logic [OPN_W-1:0] OP_BGEZ    = 7'd47;
  localparam logic [OPN_W-1:0] OP_BLEZ    = 7'd48;
  localparam logic [OPN_W-1:0] OP_BLEZALC = 7'd49;
  localparam logic [OPN_W-1:0] OP_BGEZALC = 7'd50;
  localparam logic [OPN_W-1:0] OP_BGEUC   = 7'd51;
  localparam logic [OPN_W-1:0] OP_BGTZ    = 7'd52;
  localparam logic [OPN_W-1:0] OP_BGTZALC = 7'd53;
  localparam logic [OPN_W-1:0] OP_BLTZALC = 7'd54;
  localparam logic [OPN_W-1:0] OP_BLTUC   = 7'd55;
  localparam logic [OPN_W-1:0] OP_BEQC    = 7'd56;
  localparam logic [OPN_W-1:0] OP_BOVC    = 7'd57;
  localparam logic [OPN_W-1:0] OP_BNEC    = 7'd58;
  localparam logic [OPN_W-1:0] OP_BNVC    = 7'd59;
  localparam logic [OPN_W-1:0] OP_BITSWAP = 7'd60;
  localparam logic [OPN_W-1:0] OP_ALIGN   = 7'd61;
  localparam logic [OPN_W-1:0] OP_JIC     = 7'd62;
  localparam logic [OPN_W-1:0] OP_BEQZC   = 7'd63;
  localparam logic [OPN_W-1:0] OP_ALUIPC  = 7'd64;
  localparam logic [OPN_W-1:0] OP_AUIPC   = 7'd65;
  localparam logic [OPN_W-1:0] OP_ADDIUPC = 7'd66;
  localparam logic [OPN_W-1:0] OP_JIALC   = 7'd67;
  localparam logic [OPN_W-1:0] OP_BNEZC   = 7'd68;

  // major opcodes
  localparam logic [5:0] OPC_SPECIAL = 6'd0;
  localparam logic [5:0] OPC_REGIMM  = 6'd1;
  localparam logic [5:0] OPC_J       = 6'd2;
  localparam logic [5:0] OPC_JAL     = 6'd3;
  localparam logic [5:0] OPC_BEQ     = 6'd4;
  localparam logic [5:0] OPC_BNE     = 6'd5;
  localparam logic [5:0] OPC_POP06   = 6'd6;
  localparam logic [5:0] OPC_POP07   = 6'd7;
  localparam logic [5:0] OPC_POP10   = 6'd8;
  localparam logic [5:0] OPC_ADDIU   = 6'd9;
  localparam logic [5:0] OPC_SLTI    = 6'd10;
  localparam logic [5:0] OPC_SLTIU   = 6'd11;
  localparam logic [5:0] OPC_ANDI    = 6'd12;
  localparam logic [5:0] OPC_ORI     = 6'd13;
  localparam logic [5:0] OPC_XORI    = 6'd14;
  localparam logic [5:0] OPC_AUI     = 6'd15;
  localparam logic [5:0] OPC_BGEC    = 6'd22;
  localparam logic [5:0] OPC_BLTC    = 6'd23;
  localparam logic [5:0] OPC_POP30   = 6'd24;
  localparam logic [5:0] OPC_SPECIAL3 = 6'd31;
  localparam logic [5:0] OPC_BC      = 6'd50;
  localparam logic [5:0] OPC_POP66   = 6'd54;
  localparam logic [5:0] OPC_BALC    = 6'd58;
  localparam logic [5:0] OPC_PCREL   = 6'd59;
  localparam logic [5:0] OPC_POP76   = 6'd62;

  // SPECIAL function codes
  localparam logic [5:0] FN_SLL   = 6'd0;
  localparam logic [5:0] FN_SRL   = 6'd2;
  localparam logic [5:0] FN_SRA   = 6'd3;
  localparam logic [5:0] FN_SLLV  = 6'd4;
  localparam logic [5:0] FN_LSA   = 6'd5;
  localparam logic [5:0] FN_SRLV  = 6'd6;
  localparam logic [5:0] FN_SRAV  = 6'd7;
  localparam logic [5:0] FN_JALR  = 6'd9;
  localparam logic [5:0] FN_CLZ   = 6'd16;
  localparam logic [5:0] FN_CLO   = 6'd17;
  localparam logic [5:0] FN_SOP30 = 6'd24;
  localparam logic [5:0] FN_SOP31 = 6'd25;
  localparam logic [5:0] FN_SOP32 = 6'd26;
  localparam logic [5:0] FN_SOP33 = 6'd27;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_ADDU  = 6'd33;
  localparam logic [5:0] FN_SUB   = 6'd34;
  localparam logic [5:0] FN_SUBU  = 6'd35;
  localparam logic [5:0] FN_AND   = 6'd36;
  localparam logic [5:0] FN_OR    = 6'd37;
  localparam logic [5:0] FN_XOR   = 6'd38;
  localparam logic [5:0] FN_NOR   = 6'd39;
  localparam logic [5:0] FN_SLT   = 6'd42;
  localparam logic [5:0] FN_SLTU  = 6'd43;

  // REGIMM rt codes, SPECIAL3 shamt codes, mul/div shamt selectors
  localparam logic [4:0] RT_BLTZ     = 5'd0;
  localparam logic [4:0] RT_BGEZ     = 5'd1;
  localparam logic [4:0] SA_BITSWAP  = 5'd0;
  localparam logic [2:0] SA_ALIGN_HI = 3'd2;
  localparam logic [4:0] SA_FIRST    = 5'd2;
  localparam logic [4:0] SA_SECOND   = 5'd3;

  typedef struct packed {
    logic [OPN_W-1:0]  operation;
    logic [KIND_W-1:0] operand_kind;
    logic [PACK_W-1:0] operand_pack;
    logic              is_nop;
    logic              is_unknown;
  } rid_result_t;

  function automatic logic [PACK_W-1:0] pk_regs(input logic [4:0] rd, input logic [4:0] rs,
                                                input logic [4:0] rt);
    pk_regs = {40'd0, 3'd0, rt, 3'd0, rs, 3'd0, rd};
  endfunction

  function automatic logic [PACK_W-1:0] pk_imm(input logic [4:0] a, input logic [4:0] b,
                                               input logic [31:0] imm);
    pk_imm = {imm, 16'd0, 3'd0, b, 3'd0, a};
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rid_if.sv
`default_nettype none
interface rid_in_if;
  import rid_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface rid_out_if;
  import rid_pkg::*;
  logic              valid;
  logic              ready;
  logic [OPN_W-1:0]  operation;
  logic [KIND_W-1:0] operand_kind;
  logic [PACK_W-1:0] operand_pack;
  logic              is_nop;
  logic              is_unknown;

  modport source (output valid, output operation, output operand_kind,
                  output operand_pack, output is_nop, output is_unknown, input ready);
  modport sink   (input valid, input operation, input operand_kind,
                  input operand_pack, input is_nop, input is_unknown, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/risc_instruction_decoder.sv
// Pipeline: input register, then result register; a stall on result holds both.
// Throughput: one instruction per cycle while result is not stalled; decode is a
//   single combinational pass.
// Reset (rst, synchronous): both stage valid flags clear; payload registers
//   are not reset.
`default_nettype none
module risc_instruction_decoder
  import rid_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  rid_in_if.sink     instr,
  rid_out_if.source  result
);

  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  logic              out_valid;
  rid_result_t       out_res;
  rid_result_t       dec_res;
  logic              out_load;

  rid_decode u_decode (
    .word (s1_word),
    .res  (dec_res)
  );

  assign out_load    = s1_valid && (!out_valid || result.ready);
  assign instr.ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (instr.ready) begin
        s1_valid <= instr.valid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      s1_word <= instr.instr_word;
    end
    if (out_load) begin
      out_res <= dec_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.operation    = out_res.operation;
  assign result.operand_kind = out_res.operand_kind;
  assign result.operand_pack = out_res.operand_pack;
  assign result.is_nop       = out_res.is_nop;
  assign result.is_unknown   = out_res.is_unknown;

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.is_nop && result.is_unknown))
    else $error("nop and unknown both set");

  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.is_unknown || result.is_nop)) |->
      (result.operation == '0 && result.operand_kind == '0 && result.operand_pack == '0))
    else $error("nonzero fields on nop or unknown result");

  a_op_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.operation <= OP_BNEZC))
    else $error("operation number out of range");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (instr.valid && instr.ready) |=> s1_valid)
    else $error("transfer lost at input register");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_load) |=> (s1_valid && $stable(s1_word)))
    else $error("input register changed while stalled");

endmodule
`default_nettype wire

// File: hw/rtl/rid_decode.sv
`default_nettype none
module rid_decode
  import rid_pkg::*;
(
  input  wire logic [WORD_W-1:0] word,
  output rid_result_t            res
);

  logic [5:0]        opc;
  logic [4:0]        rs;
  logic [4:0]        rt;
  logic [4:0]        rd;
  logic [4:0]        sa;
  logic [5:0]        fn;
  logic [31:0]       im;
  logic [31:0]       tgt;
  logic              nop;
  logic              known;
  logic [OPN_W-1:0]  opn;
  logic [KIND_W-1:0] kind;
  logic [PACK_W-1:0] pack;

  assign opc = word[31:26];
  assign rs  = word[25:21];
  assign rt  = word[20:16];
  assign rd  = word[15:11];
  assign sa  = word[10:6];
  assign fn  = word[5:0];
  assign im  = {16'd0, word[15:0]};
  assign tgt = {6'd0, word[25:0]};
  assign nop = (word == '0);

  always_comb begin
    known = 1'b1;
    opn   = OP_J;
    kind  = KIND_REG3;
    pack  = pk_regs(rd, rs, rt);
    unique case (opc)
      OPC_SPECIAL: begin
        unique case (fn)
          FN_SLL:  opn = OP_SLL;
          FN_SRA:  opn = OP_SRA;
          FN_SLLV: opn = OP_SLLV;
          FN_LSA:  opn = OP_LSA;
          FN_SRAV: opn = OP_SRAV;
          FN_CLZ:  opn = OP_CLZ;
          FN_CLO:  opn = OP_CLO;
          FN_ADD:  opn = OP_ADD;
          FN_ADDU: opn = OP_ADDU;
          FN_SUB:  opn = OP_SUB;
          FN_SUBU: opn = OP_SUBU;
          FN_AND:  opn = OP_AND;
          FN_OR:   opn = OP_OR;
          FN_XOR:  opn = OP_XOR;
          FN_NOR:  opn = OP_NOR;
          FN_SLT:  opn = OP_SLT;
          FN_SLTU: opn = OP_SLTU;
          FN_SRL:  opn = (rs != '0) ? OP_ROTR : OP_SRL;
          FN_SRLV: opn = (sa != '0) ? OP_ROTRV : OP_SRLV;
          FN_JALR: begin
            opn  = sa[4] ? OP_JALR_HB : OP_JALR;
            kind = KIND_RD_RS;
            pack = pk_regs(rd, rs, 5'd0);
          end
          FN_SOP30, FN_SOP31, FN_SOP32, FN_SOP33: begin
            // pair picked by fn[1:0], member by shamt
            opn   = OP_MUL + OPN_W'({fn[1:0], sa[0]});
            known = (sa == SA_FIRST) || (sa == SA_SECOND);
          end
          default: known = 1'b0;
        endcase
      end
      OPC_J, OPC_JAL, OPC_BC, OPC_BALC: begin
        unique case (opc)
          OPC_J:   opn = OP_J;
          OPC_JAL: opn = OP_JAL;
          OPC_BC:  opn = OP_BC;
          default: opn = OP_BALC;
        endcase
        kind = KIND_TARGET;
        pack = {tgt, 32'd0};
      end
      OPC_BEQ, OPC_BNE, OPC_ADDIU, OPC_SLTI, OPC_SLTIU, OPC_ANDI, OPC_ORI, OPC_XORI,
      OPC_AUI, OPC_BGEC, OPC_BLTC: begin
        unique case (opc)
          OPC_BEQ:   opn = OP_BEQ;
          OPC_BNE:   opn = OP_BNE;
          OPC_ADDIU: opn = OP_ADDIU;
          OPC_SLTI:  opn = OP_SLTI;
          OPC_SLTIU: opn = OP_SLTIU;
          OPC_ANDI:  opn = OP_ANDI;
          OPC_ORI:   opn = OP_ORI;
          OPC_XORI:  opn = OP_XORI;
          OPC_AUI:   opn = OP_AUI;
          OPC_BGEC:  opn = OP_BGEC;
          default:   opn = OP_BLTC;
        endcase
        kind = KIND_REG2_IMM;
        pack = pk_imm(rs, rt, im);
      end
      OPC_REGIMM: begin
        kind  = KIND_REG_IMM;
        pack  = pk_imm(rs, 5'd0, im);
        opn   = (rt == RT_BLTZ) ? OP_BLTZ : OP_BGEZ;
        known = (rt == RT_BLTZ) || (rt == RT_BGEZ);
      end
      OPC_POP06, OPC_POP07: begin
        kind = KIND_REG_IMM;
        if (rt == '0) begin
          opn  = (opc == OPC_POP06) ? OP_BLEZ : OP_BGTZ;
          pack = pk_imm(rs, 5'd0, im);
        end else if (rs == '0) begin
          opn  = (opc == OPC_POP06) ? OP_BLEZALC : OP_BGTZALC;
          pack = pk_imm(rt, 5'd0, im);
        end else if (rs == rt) begin
          opn  = (opc == OPC_POP06) ? OP_BGEZALC : OP_BLTZALC;
          pack = pk_imm(rt, 5'd0, im);
        end else begin
          opn  = (opc == OPC_POP06) ? OP_BGEUC : OP_BLTUC;
          kind = KIND_REG2_IMM;
          pack = pk_imm(rs, rt, im);
        end
      end
      OPC_POP10, OPC_POP30: begin
        if (opc == OPC_POP10) begin
          opn = (rs < rt) ? OP_BEQC : OP_BOVC;
        end else begin
          opn = (rs < rt) ? OP_BNEC : OP_BNVC;
        end
        kind = KIND_REG2_IMM;
        pack = pk_imm(rs, rt, im);
      end
      OPC_SPECIAL3: begin
        if (sa == SA_BITSWAP) begin
          opn  = OP_BITSWAP;
          kind = KIND_RD_RS;
          pack = pk_regs(rd, rt, 5'd0);
        end else begin
          opn   = OP_ALIGN;
          kind  = KIND_REG3_BP;
          pack  = pk_regs(rd, rs, rt) | {38'd0, sa[1:0], 24'd0};
          known = (sa[4:2] == SA_ALIGN_HI);
        end
      end
      OPC_POP66: begin
        if (rs == '0) begin
          opn  = OP_JIC;
          kind = KIND_REG_IMM;
          pack = pk_imm(rt, 5'd0, im);
        end else begin
          opn  = OP_BEQZC;
          kind = KIND_REG_WIDE;
          pack = pk_imm(rs, 5'd0, {11'd0, word[20:0]});
        end
      end
      OPC_PCREL: begin
        if (rt[4:3] != '0) begin
          opn  = rt[0] ? OP_ALUIPC : OP_AUIPC;
          kind = KIND_REG_IMM;
          pack = pk_imm(rs, 5'd0, im);
        end else begin
          opn  = OP_ADDIUPC;
          kind = KIND_REG_WIDE;
          pack = pk_imm(rs, 5'd0, {13'd0, word[18:0]});
        end
      end
      OPC_POP76: begin
        kind = KIND_REG_IMM;
        if (rs == '0) begin
          opn  = OP_JIALC;
          pack = pk_imm(rt, 5'd0, im);
        end else begin
          opn  = OP_BNEZC;
          pack = pk_imm(rs, 5'd0, im);
        end
      end
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    res.is_nop     = nop;
    res.is_unknown = !nop && !known;
    if (!nop && known) begin
      res.operation    = opn;
      res.operand_kind = kind;
      res.operand_pack = pack;
    end else begin
      res.operation    = '0;
      res.operand_kind = '0;
      res.operand_pack = '0;
    end
  end

endmodule
`default_nettype wire
